>>> hw/rtl/jdz_pkg.sv
// ============================================================================
// Joystick dead zone package
// Shared widths, stage positions, codes and sample types for the dead zone
// conditioner.
// ============================================================================
package jdz_pkg;

    // Sample format: signed, two integer bits, the rest fraction.
    localparam int SB    = 16;
    localparam int FB    = SB - 2;
    localparam int ONE   = 1 << FB;
    localparam int DZ_W  = 14;
    localparam int SQ_W  = 2 * SB;
    localparam int P_W   = SB + FB + 1;

    // Iteration counts of the three step units.
    localparam int RT_STEPS = SB;
    localparam int DZ_STEPS = FB;
    localparam int DV_STEPS = FB + 1;

    // Stage positions along the pipeline.
    localparam int ST_SUM   = 1;
    localparam int ST_RT0   = 2;
    localparam int ST_PREP  = ST_RT0 + RT_STEPS;
    localparam int ST_DZ0   = ST_PREP + 1;
    localparam int ST_SCL   = ST_DZ0 + DZ_STEPS;
    localparam int ST_DV0   = ST_SCL + 1;
    localparam int PIPE_LEN = ST_DV0 + DV_STEPS;
    localparam int N_SIDE   = PIPE_LEN - ST_PREP;

    // Register map, selected by the word address bit.
    localparam logic REG_DEAD_ZONE = 1'b0;
    localparam logic REG_ZONE_MODE = 1'b1;

    typedef enum logic [1:0] {
        MODE_AXIAL    = 2'd0,
        MODE_RADIAL   = 2'd1,
        MODE_UNSCALED = 2'd2,
        MODE_NONE     = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        KIND_BOOL  = 2'd0,
        KIND_ONE   = 2'd1,
        KIND_TWO   = 2'd2,
        KIND_THREE = 2'd3
    } t_kind;

    typedef struct packed {
        t_kind                 kind;
        logic [2:0][SB-1:0]    comp;
    } t_smp;

    // Magnitude and per-lane values that travel from the magnitude stage to the output.
    typedef struct packed {
        logic [SB-1:0]         m;
        logic [2:0][SB-1:0]    a;
        logic [2:0]            big;
        logic [2:0][FB:0]      s;
    } t_side;

    // Magnitude of a signed component; the most negative value fits unsigned.
    function automatic logic [SB-1:0] f_mag(input logic [SB-1:0] v);
        f_mag = v[SB-1] ? (~v + SB'(1)) : v;
    endfunction

endpackage

>>> hw/rtl/joystick_dead_zone.sv
// ============================================================================
// Joystick dead zone
// Pipelined dead zone conditioner for one analog stick sample per cycle when not stalled.
// ============================================================================
// Usage:
// An input beat carries a value kind and X, Y, Z components in signed Q2.14.
// It is taken when i_valid and o_ready are both high; each input beat gives
// exactly one output beat on o_valid / i_ready with the conditioned X, Y, Z.
// The block accepts one beat every cycle while the pipeline is not held. The
// stages from an accepted input beat to its output beat are, in order: the
// absolute values and squares, their sum, the square root (one result bit per
// stage), the magnitude pick, the dead zone rescale division, the scale
// product and the division by the magnitude, then the output register.
// When the receiver stalls, the output register holds its beat; the stages
// behind it keep moving only while the last stage is empty, so one more beat
// can move up to the last stage, after which the whole pipeline and the
// input hold until the output beat is taken.
// Reset clears all valid bits and loads dead_zone = 3277, zone_mode = 1.
// The user must write configuration through the APB-style port only while no
// beat is in flight; the block itself does not enforce it.
// ============================================================================
module joystick_dead_zone
    import jdz_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [1:0]           i_value_kind,
    input  logic signed [SB-1:0] i_in_x,
    input  logic signed [SB-1:0] i_in_y,
    input  logic signed [SB-1:0] i_in_z,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic signed [SB-1:0] o_out_x,
    output logic signed [SB-1:0] o_out_y,
    output logic signed [SB-1:0] o_out_z,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    localparam int LAST = PIPE_LEN - 1;

    // Configuration registers.
    logic [DZ_W-1:0] r_dead_zone;
    t_mode           r_zone_mode;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dead_zone <= DZ_W'(3277);
            r_zone_mode <= MODE_RADIAL;
        end else if (psel && penable && pwrite) begin
            case (paddr[2])
                REG_DEAD_ZONE: r_dead_zone <= pwdata[DZ_W-1:0];
                REG_ZONE_MODE: r_zone_mode <= t_mode'(pwdata[1:0]);
                default:       r_dead_zone <= r_dead_zone;
            endcase
        end
    end

    assign pready = 1'b1;
    assign prdata = paddr[2] ? 32'(r_zone_mode) : 32'(r_dead_zone);

    // Threshold at sample scale and the rescale divisor.
    logic [FB-1:0] w_thr;
    logic [FB:0]   w_den;
    logic          w_rad;
    logic          w_scaled;

    assign w_thr    = FB'(r_dead_zone) << (FB - DZ_W);
    assign w_den    = (FB+1)'(ONE) - (FB+1)'(w_thr);
    assign w_rad    = (r_zone_mode == MODE_RADIAL) || (r_zone_mode == MODE_UNSCALED);
    assign w_scaled = (r_zone_mode != MODE_UNSCALED);

    // Flow control: the pipeline moves unless a full last stage is blocked.
    logic r_vld [PIPE_LEN];
    logic r_ov;
    logic w_out_load;
    logic w_en;

    assign w_out_load = !r_ov || i_ready;
    assign w_en       = w_out_load || !r_vld[LAST];
    assign o_ready    = w_en;
    assign o_valid    = r_ov;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < PIPE_LEN; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else if (w_en) begin
            r_vld[0] <= i_valid;
            for (int k = 1; k < PIPE_LEN; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
        end
    end

    // Sample payload travels alongside the valid bits.
    t_smp r_smp [PIPE_LEN];
    t_smp w_in_smp;

    assign w_in_smp.kind    = t_kind'(i_value_kind);
    assign w_in_smp.comp[0] = i_in_x;
    assign w_in_smp.comp[1] = i_in_y;
    assign w_in_smp.comp[2] = i_in_z;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_smp[0] <= w_in_smp;
            for (int k = 1; k < PIPE_LEN; k++) begin
                r_smp[k] <= r_smp[k-1];
            end
        end
    end

    // Squares of the component magnitudes.
    logic [SQ_W-1:0] r_sq [3];
    logic [SB-1:0]   w_in_mag [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_in_mag[i] = f_mag(w_in_smp.comp[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < 3; i++) begin
                r_sq[i] <= w_in_mag[i] * w_in_mag[i];
            end
        end
    end

    // Sum of squares; Z counts only for three-axis samples.
    logic [SQ_W-1:0] r_sum;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sum <= r_sq[0] + r_sq[1] +
                     ((r_smp[0].kind == KIND_THREE) ? r_sq[2] : '0);
        end
    end

    // Square root, one result bit per stage.
    logic [SQ_W-1:0] r_rt_n [RT_STEPS];
    logic [SQ_W-1:0] r_rt_r [RT_STEPS];

    for (genvar g = 0; g < RT_STEPS; g++) begin : g_rt
        localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (SQ_W - 2 - 2 * g);
        logic [SQ_W-1:0] w_n_in;
        logic [SQ_W-1:0] w_r_in;
        logic [SQ_W-1:0] w_trial;

        if (g == 0) begin : g_first
            assign w_n_in = r_sum;
            assign w_r_in = '0;
        end else begin : g_next
            assign w_n_in = r_rt_n[g-1];
            assign w_r_in = r_rt_r[g-1];
        end

        assign w_trial = w_r_in + BIT;

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                if (w_n_in >= w_trial) begin
                    r_rt_n[g] <= w_n_in - w_trial;
                    r_rt_r[g] <= (w_r_in >> 1) + BIT;
                end else begin
                    r_rt_n[g] <= w_n_in;
                    r_rt_r[g] <= w_r_in >> 1;
                end
            end
        end
    end

    // Magnitude pick per lane and start of the rescale division.
    t_side         r_side   [N_SIDE];
    logic [FB:0]   r_dz_rem0 [3];
    t_smp          w_pp_smp;
    logic [SB-1:0] w_m;
    logic          w_pp_vec;
    t_side         w_pp_side;
    logic [FB:0]   w_pp_rem [3];

    assign w_pp_smp = r_smp[ST_PREP-1];
    assign w_m      = r_rt_r[RT_STEPS-1][SB-1:0];
    assign w_pp_vec = w_rad && ((w_pp_smp.kind == KIND_TWO) ||
                                (w_pp_smp.kind == KIND_THREE));

    always_comb begin
        logic [SB-1:0] a;
        logic [SB-1:0] num;
        w_pp_side   = '0;
        w_pp_side.m = w_m;
        for (int i = 0; i < 3; i++) begin
            a = (i == 0 && w_pp_vec) ? w_m : f_mag(w_pp_smp.comp[i]);
            num = (a > SB'(w_thr)) ? (a - SB'(w_thr)) : '0;
            w_pp_side.a[i]   = a;
            w_pp_side.big[i] = (num >= SB'(w_den));
            w_pp_rem[i]      = w_pp_side.big[i] ? '0 : num[FB:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_side[0] <= w_pp_side;
            for (int i = 0; i < 3; i++) begin
                r_dz_rem0[i] <= w_pp_rem[i];
            end
        end
    end

    // Rescale division: (a - thr) * ONE / (ONE - thr), one quotient bit a stage.
    logic [FB:0]   r_dz_rem [DZ_STEPS][3];
    logic [FB-1:0] r_dz_q   [DZ_STEPS][3];

    for (genvar g = 0; g < DZ_STEPS; g++) begin : g_dz
        for (genvar l = 0; l < 3; l++) begin : g_lane
            logic [FB:0]   w_rem_in;
            logic [FB-1:0] w_q_in;
            logic [FB+1:0] w_t;

            if (g == 0) begin : g_first
                assign w_rem_in = r_dz_rem0[l];
                assign w_q_in   = '0;
            end else begin : g_next
                assign w_rem_in = r_dz_rem[g-1][l];
                assign w_q_in   = r_dz_q[g-1][l];
            end

            assign w_t = {w_rem_in, 1'b0};

            always_ff @(posedge i_clk) begin
                if (w_en) begin
                    if (w_t >= (FB+2)'(w_den)) begin
                        r_dz_rem[g][l] <= (FB+1)'(w_t - (FB+2)'(w_den));
                        r_dz_q[g][l]   <= {w_q_in[FB-2:0], 1'b1};
                    end else begin
                        r_dz_rem[g][l] <= w_t[FB:0];
                        r_dz_q[g][l]   <= {w_q_in[FB-2:0], 1'b0};
                    end
                end
            end
        end
    end

    // Side values ride along; the scaled magnitudes join at the scale stage.
    t_side w_sc_side;

    for (genvar k = 1; k < N_SIDE; k++) begin : g_side
        if (k == ST_SCL - ST_PREP) begin : g_scl
            always_ff @(posedge i_clk) begin
                if (w_en) begin
                    r_side[k] <= w_sc_side;
                end
            end
        end else begin : g_copy
            always_ff @(posedge i_clk) begin
                if (w_en) begin
                    r_side[k] <= r_side[k-1];
                end
            end
        end
    end

    // Scaled magnitude per lane and the product for the radial vector case.
    t_side          w_sc_in;
    t_smp           w_sc_smp;
    logic [P_W-1:0] r_p [3];

    assign w_sc_in  = r_side[ST_SCL-1-ST_PREP];
    assign w_sc_smp = r_smp[ST_SCL-1];

    always_comb begin
        logic [SB-1:0] a;
        w_sc_side = w_sc_in;
        for (int i = 0; i < 3; i++) begin
            a = w_sc_in.a[i];
            if (w_scaled) begin
                w_sc_side.s[i] = w_sc_in.big[i] ? (FB+1)'(ONE)
                                                : {1'b0, r_dz_q[DZ_STEPS-1][i]};
            end else if (a < SB'(w_thr)) begin
                w_sc_side.s[i] = '0;
            end else if (a > SB'(ONE)) begin
                w_sc_side.s[i] = (FB+1)'(ONE);
            end else begin
                w_sc_side.s[i] = a[FB:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < 3; i++) begin
                r_p[i] <= f_mag(w_sc_smp.comp[i]) * w_sc_side.s[0];
            end
        end
    end

    // Division of the product by the magnitude, one quotient bit a stage.
    logic [P_W-1:0]      r_dv_p   [DV_STEPS][3];
    logic [SB-1:0]       r_dv_rem [DV_STEPS][3];
    logic [DV_STEPS-1:0] r_dv_q   [DV_STEPS][3];

    for (genvar g = 0; g < DV_STEPS; g++) begin : g_dv
        for (genvar l = 0; l < 3; l++) begin : g_lane
            logic [P_W-1:0]      w_p_in;
            logic [SB-1:0]       w_rem_in;
            logic [DV_STEPS-1:0] w_q_in;
            logic [SB:0]         w_t;
            logic [SB-1:0]       w_div;

            if (g == 0) begin : g_first
                assign w_p_in   = r_p[l];
                assign w_rem_in = r_p[l][P_W-1:DV_STEPS];
                assign w_q_in   = '0;
            end else begin : g_next
                assign w_p_in   = r_dv_p[g-1][l];
                assign w_rem_in = r_dv_rem[g-1][l];
                assign w_q_in   = r_dv_q[g-1][l];
            end

            assign w_div = r_side[ST_DV0 + g - 1 - ST_PREP].m;
            assign w_t   = {w_rem_in, w_p_in[DV_STEPS-1-g]};

            always_ff @(posedge i_clk) begin
                if (w_en) begin
                    r_dv_p[g][l] <= w_p_in;
                    if (w_t >= (SB+1)'(w_div)) begin
                        r_dv_rem[g][l] <= SB'(w_t - (SB+1)'(w_div));
                        r_dv_q[g][l]   <= {w_q_in[DV_STEPS-2:0], 1'b1};
                    end else begin
                        r_dv_rem[g][l] <= w_t[SB-1:0];
                        r_dv_q[g][l]   <= {w_q_in[DV_STEPS-2:0], 1'b0};
                    end
                end
            end
        end
    end

    // Output selection by mode and kind, with the component sign restored.
    t_smp               w_o_smp;
    t_side              w_o_side;
    logic [2:0][SB-1:0] w_out;

    assign w_o_smp  = r_smp[LAST];
    assign w_o_side = r_side[N_SIDE-1];

    always_comb begin
        logic [SB-1:0] v;
        logic [SB-1:0] s_ax;
        logic [SB-1:0] s_vec;
        logic [SB-1:0] r_ax;
        logic [SB-1:0] r_vec;
        for (int i = 0; i < 3; i++) begin
            v     = w_o_smp.comp[i];
            s_ax  = SB'(w_o_side.s[i]);
            s_vec = SB'(r_dv_q[DV_STEPS-1][i]);
            r_ax  = v[SB-1] ? (~s_ax + SB'(1)) : s_ax;
            r_vec = v[SB-1] ? (~s_vec + SB'(1)) : s_vec;
            if (w_o_smp.kind == KIND_BOOL) begin
                w_out[i] = v;
            end else begin
                case (r_zone_mode)
                    MODE_AXIAL: begin
                        w_out[i] = r_ax;
                    end
                    MODE_RADIAL, MODE_UNSCALED: begin
                        if (w_o_smp.kind == KIND_ONE) begin
                            w_out[i] = (i == 0) ? r_ax : v;
                        end else if (w_o_side.m == '0 ||
                                     (i == 2 && w_o_smp.kind == KIND_TWO)) begin
                            w_out[i] = '0;
                        end else begin
                            w_out[i] = r_vec;
                        end
                    end
                    default: begin
                        w_out[i] = v;
                    end
                endcase
            end
        end
    end

    // Output register.
    logic [2:0][SB-1:0] r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_out_load) begin
            r_ov <= r_vld[LAST];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load && r_vld[LAST]) begin
            r_out <= w_out;
        end
    end

    assign o_out_x = r_out[0];
    assign o_out_y = r_out[1];
    assign o_out_z = r_out[2];

    // The pipeline only holds when a full last stage faces a blocked output.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |-> (r_ov && r_vld[LAST]))
        else $error("pipeline stalled without a blocked output beat");

    // The root of a sum of squares fits the sample width.
    a_root_width: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[ST_PREP-1] |-> (r_rt_r[RT_STEPS-1][SQ_W-1:SB] == '0))
        else $error("square root exceeds sample width");

    // The rescale remainder stays below the divisor in every lane.
    a_dz_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[ST_SCL-1] |-> ((r_dz_rem[DZ_STEPS-1][0] < w_den) &&
                             (r_dz_rem[DZ_STEPS-1][1] < w_den) &&
                             (r_dz_rem[DZ_STEPS-1][2] < w_den)))
        else $error("rescale division remainder out of range");

endmodule

>>> sim/testbench.sv
`timescale 1ns / 1ps
// ============================================================================
// Joystick dead zone testbench
// Drives stick samples through the conditioner under random idling on both
// sides, predicts each conditioned sample in integer arithmetic and compares
// every output beat field by field, across several dead zone and mode settings.
// ============================================================================
module testbench;
    import jdz_pkg::*;

    localparam int LATENCY = 50;
    localparam int LIMIT   = 2000000;
    localparam int N_RAND  = 1500;

    typedef struct {
        logic [SB-1:0] x;
        logic [SB-1:0] y;
        logic [SB-1:0] z;
    } t_vec;

    // Directed rows: kind, components, and an optional typed-in result.
    typedef struct {
        t_kind         kind;
        logic [SB-1:0] x;
        logic [SB-1:0] y;
        logic [SB-1:0] z;
        bit            fixed;
        logic [SB-1:0] ex;
        logic [SB-1:0] ey;
        logic [SB-1:0] ez;
    } t_row;

    logic          i_clk;
    logic          i_rst_n;
    logic          i_valid;
    logic          o_ready;
    logic [1:0]    i_value_kind;
    logic [SB-1:0] i_in_x;
    logic [SB-1:0] i_in_y;
    logic [SB-1:0] i_in_z;
    logic          o_valid;
    logic          i_ready;
    logic [SB-1:0] o_out_x;
    logic [SB-1:0] o_out_y;
    logic [SB-1:0] o_out_z;
    logic          psel;
    logic          penable;
    logic          pwrite;
    logic [2:0]    paddr;
    logic [31:0]   pwdata;
    logic [31:0]   prdata;
    logic          pready;

    // Shadow copy of the configuration registers.
    logic [DZ_W-1:0] dz_shadow;
    t_mode           mode_shadow;

    t_vec   pending_samples[$];
    int     errors;
    int     beats_out;
    longint cycles;
    bit     rx_enable;
    int     rx_hold;

    joystick_dead_zone u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_value_kind (i_value_kind),
        .i_in_x       (i_in_x),
        .i_in_y       (i_in_y),
        .i_in_z       (i_in_z),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_out_x      (o_out_x),
        .o_out_y      (o_out_y),
        .o_out_z      (o_out_z),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Watchdog on total run length.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    function automatic longint clamp_sample(longint v);
        longint hi;
        longint lo;
        hi = (longint'(1) << (SB - 1)) - 1;
        lo = -(longint'(1) << (SB - 1));
        if (v > hi) return hi;
        if (v < lo) return lo;
        return v;
    endfunction

    function automatic longint rescale_mag(longint a, longint thr);
        longint r;
        if (a - thr <= 0) return 0;
        r = ((a - thr) * ONE) / (ONE - thr);
        return (r > ONE) ? ONE : r;
    endfunction

    function automatic longint clip_mag(longint a, longint thr);
        if (a < thr) return 0;
        return (a > ONE) ? ONE : a;
    endfunction

    function automatic longint cond_axis(longint v, longint thr, bit scaled);
        longint a;
        longint m;
        a = (v < 0) ? -v : v;
        m = scaled ? rescale_mag(a, thr) : clip_mag(a, thr);
        return (v < 0) ? -m : m;
    endfunction

    function automatic longint int_sqrt(longint n);
        longint root;
        longint b;
        root = 0;
        b = longint'(1) << 60;
        while (b > n) b = b >> 2;
        while (b != 0) begin
            if (n >= root + b) begin
                n = n - (root + b);
                root = (root >> 1) + b;
            end else begin
                root = root >> 1;
            end
            b = b >> 2;
        end
        return root;
    endfunction

    // Conditioned sample for the current shadow configuration.
    function automatic t_vec condition_sample(t_kind kind, t_vec s);
        longint v[3];
        longint r[3];
        longint thr;
        longint sq;
        longint m;
        longint sc;
        int     used;
        bit     scaled;
        t_vec   o;
        v[0] = longint'($signed(s.x));
        v[1] = longint'($signed(s.y));
        v[2] = longint'($signed(s.z));
        r = v;
        thr = longint'(dz_shadow) << (FB - DZ_W);
        scaled = (mode_shadow == MODE_RADIAL);
        if (kind != KIND_BOOL) begin
            if (mode_shadow == MODE_AXIAL) begin
                for (int i = 0; i < 3; i++) r[i] = cond_axis(v[i], thr, 1'b1);
            end else if (mode_shadow != MODE_NONE) begin
                if (kind == KIND_ONE) begin
                    r[0] = cond_axis(v[0], thr, scaled);
                end else begin
                    used = (kind == KIND_THREE) ? 3 : 2;
                    sq = 0;
                    for (int i = 0; i < used; i++) sq += v[i] * v[i];
                    m = int_sqrt(sq);
                    sc = scaled ? rescale_mag(m, thr) : clip_mag(m, thr);
                    for (int i = 0; i < 3; i++) begin
                        r[i] = (i >= used || m == 0) ? 0 : (v[i] * sc) / m;
                    end
                end
            end
        end
        o.x = SB'(clamp_sample(r[0]));
        o.y = SB'(clamp_sample(r[1]));
        o.z = SB'(clamp_sample(r[2]));
        return o;
    endfunction

    // Output side: random stalls, compare each beat with the oldest prediction.
    always @(posedge i_clk) begin
        if (rx_enable) begin
            if (rx_hold > 0) begin
                rx_hold <= rx_hold - 1;
                i_ready <= 1'b0;
            end else if ($urandom_range(0, 99) < 2) begin
                rx_hold <= $urandom_range(10, 60);
                i_ready <= 1'b0;
            end else begin
                i_ready <= ($urandom_range(0, 9) < 7);
            end
        end
        if (o_valid && i_ready) begin
            beats_out <= beats_out + 1;
            if (pending_samples.size() == 0) begin
                $error("output beat with no sample pending");
                errors++;
            end else begin
                t_vec e;
                e = pending_samples.pop_front();
                if (o_out_x !== e.x) begin
                    $error("out_x expected %0d got %0d", $signed(e.x), $signed(o_out_x));
                    errors++;
                end
                if (o_out_y !== e.y) begin
                    $error("out_y expected %0d got %0d", $signed(e.y), $signed(o_out_y));
                    errors++;
                end
                if (o_out_z !== e.z) begin
                    $error("out_z expected %0d got %0d", $signed(e.z), $signed(o_out_z));
                    errors++;
                end
            end
        end
    end

    // Idle cycles with the input valid dropped.
    task automatic idle_cycles(int n);
        if (n > 0) i_valid <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    // Random gap: most often none, otherwise mostly short and sometimes long.
    task automatic sender_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return;
        if (r < 95) idle_cycles($urandom_range(1, 3));
        else idle_cycles($urandom_range(10, 60));
    endtask

    task automatic apb_write(logic [2:0] addr, logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Drain the pipeline, then load new settings.
    task automatic set_config(logic [DZ_W-1:0] dz, t_mode mode);
        idle_cycles(1);
        while (pending_samples.size() != 0) @(posedge i_clk);
        idle_cycles(3);
        apb_write(3'(4 * REG_DEAD_ZONE), 32'(dz));
        apb_write(3'(4 * REG_ZONE_MODE), 32'(mode));
        dz_shadow   = dz;
        mode_shadow = mode;
    endtask

    // Send one beat; the prediction is queued at acceptance.
    task automatic send_sample(t_kind kind, t_vec s, bit fixed, t_vec fixed_out);
        t_vec e;
        i_valid      <= 1'b1;
        i_value_kind <= kind;
        i_in_x       <= s.x;
        i_in_y       <= s.y;
        i_in_z       <= s.z;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        e = fixed ? fixed_out : condition_sample(kind, s);
        pending_samples.push_back(e);
    endtask

    function automatic logic [SB-1:0] rand_comp();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return 16'h8000;
        if (r == 1) return 16'h7FFF;
        if (r < 5) return SB'($signed($urandom_range(0, 2 * ONE)) - ONE);
        if (r < 7) return SB'($signed($urandom_range(0, 6000)) - 3000);
        return SB'($urandom());
    endfunction

    t_row dir_rows[$];

    initial begin
        t_vec s;
        t_vec none;
        logic [DZ_W-1:0] dz_set[5];
        none = '{x: '0, y: '0, z: '0};
        cycles = 0; errors = 0; beats_out = 0; rx_enable = 1'b0; rx_hold = 0;
        i_rst_n = 1'b0; i_valid = 1'b0; i_ready = 1'b0;
        i_value_kind = '0; i_in_x = '0; i_in_y = '0; i_in_z = '0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        dz_shadow = 14'd3277;
        mode_shadow = MODE_RADIAL;
        idle_cycles(11);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        rx_enable = 1'b1;

        // Directed samples at reset settings: pass-through, zero magnitude,
        // full deflection, extremes and each kind.
        dir_rows = '{
            '{KIND_BOOL, 16'h8000, 16'h7FFF, 16'h1234, 1, 16'h8000, 16'h7FFF, 16'h1234},
            '{KIND_TWO, 16'h0000, 16'h0000, 16'h5555, 1, 16'h0000, 16'h0000, 16'h0000},
            '{KIND_THREE, 16'h0000, 16'h0000, 16'h0000, 1, 16'h0000, 16'h0000, 16'h0000},
            '{KIND_ONE, 16'h4000, 16'h1111, 16'h2222, 1, 16'h4000, 16'h1111, 16'h2222},
            '{KIND_ONE, 16'hC000, 16'h8000, 16'h7FFF, 1, 16'hC000, 16'h8000, 16'h7FFF},
            '{KIND_ONE, 16'h0100, 16'h0, 16'h0, 1, 16'h0, 16'h0, 16'h0},
            '{KIND_TWO, 16'h8000, 16'h8000, 16'h7FFF, 0, '0, '0, '0},
            '{KIND_THREE, 16'h8000, 16'h8000, 16'h8000, 0, '0, '0, '0},
            '{KIND_THREE, 16'h7FFF, 16'h7FFF, 16'h7FFF, 0, '0, '0, '0},
            '{KIND_TWO, 16'h0CCD, 16'h0000, 16'h0001, 0, '0, '0, '0},
            '{KIND_TWO, 16'h2000, 16'hE000, 16'h0, 0, '0, '0, '0},
            '{KIND_THREE, 16'h0001, 16'hFFFF, 16'h0001, 0, '0, '0, '0},
            '{KIND_ONE, 16'h8000, 16'h0, 16'h0, 0, '0, '0, '0}
        };
        foreach (dir_rows[i]) begin
            s = '{x: dir_rows[i].x, y: dir_rows[i].y, z: dir_rows[i].z};
            send_sample(dir_rows[i].kind, s, dir_rows[i].fixed,
                '{x: dir_rows[i].ex, y: dir_rows[i].ey, z: dir_rows[i].ez});
        end

        // Each mode, with zero, extreme and random dead zones.
        dz_set = '{14'd0, 14'd16383, 14'd3277, 14'($urandom()), 14'($urandom())};
        for (int ph = 0; ph < 12; ph++) begin
            set_config(dz_set[ph % 5], t_mode'(ph % 4));
            foreach (dir_rows[i]) begin
                s = '{x: dir_rows[i].x, y: dir_rows[i].y, z: dir_rows[i].z};
                send_sample(dir_rows[i].kind, s, 1'b0, none);
            end
            for (int n = 0; n < N_RAND / 12; n++) begin
                sender_gap();
                s = '{x: rand_comp(), y: rand_comp(), z: rand_comp()};
                send_sample(t_kind'($urandom_range(0, 3)), s, 1'b0, none);
            end
        end

        idle_cycles(1);
        while (pending_samples.size() != 0) @(posedge i_clk);
        idle_cycles(LATENCY + 10);
        $display("Covered %0d output beats over all four modes and dead zones 0 to 16383.",
            beats_out);
        if (errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
